/* rtl/iole_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iole_pkg
// Operation and status codes and the response bundle of the ordered list
// engine.
// ----------------------------------------------------------------------------
package iole_pkg;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned STAT_W  = 2;

  typedef enum logic [KIND_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_POP    = 3'd2,
    OP_DELETE = 3'd3,
    OP_GET    = 3'd4,
    OP_SET    = 3'd5,
    OP_SIZE   = 3'd6
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic [LEN_W-1:0]          length;
    status_t                   status;
  } rsp_t;

endpackage
`default_nettype wire

/* rtl/iole_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iole_store
// Register-held list entries and length; evaluates one request against the
// current contents and shifts all entries in parallel on insert and delete.
// ----------------------------------------------------------------------------
module iole_store import iole_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic [KIND_W-1:0]         kind,
  input  wire logic [POS_W-1:0]          position,
  input  wire logic signed [VALUE_W-1:0] value,
  output rsp_t                           rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [DATA_WIDTH-1:0] ent_r   [CAPACITY];
  logic [DATA_WIDTH-1:0] ent_nxt [CAPACITY];
  logic [CW-1:0]         cnt_r;
  logic [CW-1:0]         cnt_nxt;

  logic [PW-1:0]         posx;
  logic [PW-1:0]         cntx;
  logic [CW-1:0]         tail_sub;
  logic [IW-1:0]         rd_idx;
  logic [DATA_WIDTH-1:0] rd_word;
  logic [DATA_WIDTH-1:0] wr_word;
  logic signed [63:0]    value_x;
  logic [63:0]           rd_x;
  logic                  full;
  logic                  empty;
  logic                  ins_ok;
  logic                  del_ok;
  logic                  set_ok;
  logic                  pop_ok;
  logic                  get_ok;
  status_t               status;
  op_t                   op;

  assign op       = op_t'(kind);
  assign posx     = PW'(position);
  assign cntx     = PW'(cnt_r);
  assign full     = (cnt_r == CW'(CAPACITY));
  assign empty    = (cnt_r == '0);
  assign tail_sub = cnt_r - CW'(1);
  assign rd_idx   = (op == OP_POP) ? tail_sub[IW-1:0] : posx[IW-1:0];
  assign rd_word  = ent_r[rd_idx];
  assign value_x  = 64'(value);
  assign wr_word  = value_x[DATA_WIDTH-1:0];
  assign rd_x     = 64'(rd_word);

  always_comb begin
    status = ST_OK;
    ins_ok = 1'b0;
    del_ok = 1'b0;
    set_ok = 1'b0;
    pop_ok = 1'b0;
    get_ok = 1'b0;
    case (op)
      OP_APPEND: begin
        if (full) status = ST_FULL;
        else      ins_ok = 1'b1;
      end
      OP_INSERT: begin
        if (full)              status = ST_FULL;
        else if (posx > cntx)  status = ST_RANGE;
        else                   ins_ok = 1'b1;
      end
      OP_POP: begin
        if (empty) status = ST_EMPTY;
        else       pop_ok = 1'b1;
      end
      OP_DELETE, OP_GET, OP_SET: begin
        if (empty)              status = ST_EMPTY;
        else if (posx >= cntx)  status = ST_RANGE;
        else if (op == OP_GET)  get_ok = 1'b1;
        else if (op == OP_SET)  set_ok = 1'b1;
        else                    del_ok = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    logic [PW-1:0] ins_pos;
    ins_pos = (op == OP_APPEND) ? cntx : posx;
    cnt_nxt = cnt_r;
    if (ins_ok)               cnt_nxt = cnt_r + CW'(1);
    else if (pop_ok || del_ok) cnt_nxt = tail_sub;
    for (int i = 0; i < CAPACITY; i++) begin
      ent_nxt[i] = ent_r[i];
      if (ins_ok) begin
        if (PW'(i) == ins_pos)     ent_nxt[i] = wr_word;
        else if (PW'(i) > ins_pos) ent_nxt[i] = ent_r[(i > 0) ? i - 1 : 0];
      end else if (del_ok) begin
        if (PW'(i) >= posx)        ent_nxt[i] = ent_r[(i + 1 < CAPACITY) ? i + 1 : i];
      end else if (set_ok) begin
        if (PW'(i) == posx)        ent_nxt[i] = wr_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (en) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ent_r <= ent_nxt;
    end
  end

  assign rsp.read_value = (pop_ok || del_ok || get_ok) ? rd_x[VALUE_W-1:0] : '0;
  assign rsp.length     = LEN_W'(cnt_nxt);
  assign rsp.status     = status;

endmodule
`default_nettype wire

/* rtl/indexed_ordered_list_engine_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Response path: a request accepted into the input register moves into the
// response register once that register is free or the sink takes its contents;
// the list update lands with it.
// Throughput: one request per cycle while the sink does not stall the output; the
// parallel-shift entry registers settle every operation in a single pass.
// Reset: synchronous active-low rst_n empties the list and drops both stages.
// ----------------------------------------------------------------------------
// indexed_ordered_list_engine_unit
// Bounded ordered list of signed words with append, insert, pop, delete, get,
// set and size requests, one response per request.
// ----------------------------------------------------------------------------
module indexed_ordered_list_engine_unit import iole_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // position[4:0], value[36:5], zero[39:37]
  input  wire logic [2:0]  in_tuser,   // kind[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // read_value[31:0], length[36:32],
                                       // status[38:37], zero[39]
);

  logic                      req_vld_r;
  logic [KIND_W-1:0]         kind_r;
  logic [POS_W-1:0]          pos_r;
  logic signed [VALUE_W-1:0] value_r;
  logic                      rsp_vld_r;
  rsp_t                      rsp_r;
  rsp_t                      rsp;
  logic                      advance;

  assign advance   = req_vld_r && (!rsp_vld_r || out_tready);
  assign in_tready = !req_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      rsp_vld_r <= 1'b0;
    end else begin
      if (in_tready) req_vld_r <= in_tvalid;
      if (advance) rsp_vld_r <= 1'b1;
      else if (out_tready) rsp_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r  <= in_tuser;
      pos_r   <= in_tdata[POS_W-1:0];
      value_r <= in_tdata[POS_W+VALUE_W-1:POS_W];
    end
    if (advance) begin
      rsp_r <= rsp;
    end
  end

  iole_store #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .kind     (kind_r),
    .position (pos_r),
    .value    (value_r),
    .rsp      (rsp)
  );

  assign out_tvalid = rsp_vld_r;
  assign out_tdata  = {1'b0, rsp_r.status, rsp_r.length, rsp_r.read_value};

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && rsp_r.status == ST_FULL) |-> rsp_r.length == LEN_W'(CAPACITY))
    else $error("full status with length below capacity");

  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && rsp_r.status == ST_EMPTY) |-> rsp_r.length == '0)
    else $error("empty status with nonzero length");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && rsp_r.status != ST_OK) |-> rsp_r.read_value == '0)
    else $error("failed request returned data");

endmodule
`default_nettype wire

/* dv/indexed_ordered_list_engine_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_ordered_list_engine_unit_tb
// Drives list requests over the request stream and scores every response
// against a cycle-free model of the bounded list, or a typed directed row's
// expected response. The run opens with a table of directed requests (empty
// list, out-of-range positions, extreme words, unused kind code). Random phases
// follow that fill the list to capacity, drain it and mix all kinds. Both
// stream sides idle at random, the sink holds off long enough to back up the
// block, and the source pauses once until everything has drained.
// ----------------------------------------------------------------------------
module indexed_ordered_list_engine_unit_tb;
  import iole_pkg::*;

  localparam int unsigned   CAPACITY    = 16;
  localparam int unsigned   RAND_REQS   = 1150;
  localparam int unsigned   PHASE_LEN   = 48;
  localparam int unsigned   IDLE_PCT    = 30;
  localparam int unsigned   PAUSE_AT    = 700;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_ANY} mix_t;

  typedef struct {
    logic [KIND_W-1:0]         kind;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } list_req_t;

  typedef struct {
    list_req_t req;
    bit        typed;
    rsp_t      rsp;
  } directed_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic [2:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  logic signed [VALUE_W-1:0] list_words [CAPACITY];
  int unsigned               list_len = 0;
  rsp_t                      pending_rsps [$];
  directed_row_t             directed_reqs [$];
  int unsigned               mismatch_count = 0;

  indexed_ordered_list_engine_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_400_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic rsp_t apply_list_op(input list_req_t req);
    rsp_t        rsp;
    int unsigned pos;
    int unsigned i;
    rsp.read_value = '0;
    rsp.status     = ST_OK;
    pos            = 32'(req.position);
    case (req.kind)
      OP_APPEND, OP_INSERT: begin
        if (req.kind == OP_APPEND) pos = list_len;
        if (list_len >= CAPACITY) begin
          rsp.status = ST_FULL;
        end else if (pos > list_len) begin
          rsp.status = ST_RANGE;
        end else begin
          for (i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = req.value;
          list_len++;
        end
      end
      OP_POP: begin
        if (list_len == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          list_len--;
          rsp.read_value = list_words[list_len];
        end
      end
      OP_DELETE, OP_GET, OP_SET: begin
        if (list_len == 0) begin
          rsp.status = ST_EMPTY;
        end else if (pos >= list_len) begin
          rsp.status = ST_RANGE;
        end else if (req.kind == OP_GET) begin
          rsp.read_value = list_words[pos];
        end else if (req.kind == OP_SET) begin
          list_words[pos] = req.value;
        end else begin
          rsp.read_value = list_words[pos];
          for (i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      default: ;
    endcase
    rsp.length = list_len[LEN_W-1:0];
    return rsp;
  endfunction

  function automatic list_req_t random_request(input mix_t mix);
    list_req_t   req;
    int unsigned roll;
    int unsigned w_add, w_ins, w_pop, w_del;
    case (mix)
      MIX_FILL: begin
        w_add = 40; w_ins = 30; w_pop = 6;  w_del = 6;
      end
      MIX_DRAIN: begin
        w_add = 8;  w_ins = 8;  w_pop = 30; w_del = 30;
      end
      default: begin
        w_add = 16; w_ins = 16; w_pop = 14; w_del = 14;
      end
    endcase
    roll = $urandom_range(99);
    if (roll < w_add) begin
      req.kind = OP_APPEND;
    end else if (roll < w_add + w_ins) begin
      req.kind = OP_INSERT;
    end else if (roll < w_add + w_ins + w_pop) begin
      req.kind = OP_POP;
    end else if (roll < w_add + w_ins + w_pop + w_del) begin
      req.kind = OP_DELETE;
    end else begin
      roll = $urandom_range(99);
      if (roll < 40)      req.kind = OP_GET;
      else if (roll < 80) req.kind = OP_SET;
      else if (roll < 95) req.kind = OP_SIZE;
      else                req.kind = KIND_UNUSED;
    end
    if ($urandom_range(99) < 15)    req.position = POS_W'($urandom_range(16));
    else if (req.kind == OP_INSERT) req.position = POS_W'($urandom_range(list_len));
    else if (list_len > 0)          req.position = POS_W'($urandom_range(list_len - 1));
    else                            req.position = '0;
    roll = $urandom_range(99);
    if (roll < 3)       req.value = 32'sh7FFF_FFFF;
    else if (roll < 6)  req.value = 32'sh8000_0000;
    else if (roll < 8)  req.value = 32'sh0000_0000;
    else if (roll < 10) req.value = -32'sd1;
    else                req.value = $urandom;
    return req;
  endfunction

  initial begin : req_source
    list_req_t   req;
    rsp_t        rsp;
    mix_t        mix;
    int unsigned n;
    int unsigned total;
    int unsigned idle;
    int unsigned pct;

    directed_reqs.push_back('{'{OP_SIZE,   5'd0,  32'sd0},       1'b1, '{32'sd0, 5'd0, ST_OK}});
    directed_reqs.push_back('{'{OP_POP,    5'd0,  32'sd0},       1'b1, '{32'sd0, 5'd0, ST_EMPTY}});
    directed_reqs.push_back('{'{OP_GET,    5'd0,  32'sd0},       1'b1, '{32'sd0, 5'd0, ST_EMPTY}});
    directed_reqs.push_back('{'{OP_DELETE, 5'd0,  32'sd0},       1'b1, '{32'sd0, 5'd0, ST_EMPTY}});
    directed_reqs.push_back('{'{OP_SET,    5'd0,  32'sd5},       1'b1, '{32'sd0, 5'd0, ST_EMPTY}});
    directed_reqs.push_back('{'{OP_INSERT, 5'd1,  32'sd9},       1'b1, '{32'sd0, 5'd0, ST_RANGE}});
    directed_reqs.push_back('{'{OP_APPEND, 5'd0,  32'sh7FFF_FFFF}, 1'b1, '{32'sd0, 5'd1, ST_OK}});
    directed_reqs.push_back('{'{OP_APPEND, 5'd31, 32'sh8000_0000}, 1'b1, '{32'sd0, 5'd2, ST_OK}});
    directed_reqs.push_back('{'{OP_INSERT, 5'd0,  -32'sd1},      1'b1, '{32'sd0, 5'd3, ST_OK}});
    directed_reqs.push_back('{'{OP_INSERT, 5'd3,  32'sd0},       1'b1, '{32'sd0, 5'd4, ST_OK}});
    directed_reqs.push_back('{'{OP_GET,    5'd4,  32'sd0},       1'b1, '{32'sd0, 5'd4, ST_RANGE}});
    directed_reqs.push_back('{'{OP_SET,    5'd16, 32'sd1},       1'b1, '{32'sd0, 5'd4, ST_RANGE}});
    directed_reqs.push_back('{'{OP_DELETE, 5'd4,  32'sd0},       1'b1, '{32'sd0, 5'd4, ST_RANGE}});
    directed_reqs.push_back('{'{OP_INSERT, 5'd16, 32'sd2},       1'b1, '{32'sd0, 5'd4, ST_RANGE}});
    directed_reqs.push_back('{'{OP_GET,    5'd0,  32'sd0},       1'b0, '{32'sd0, 5'd0, ST_OK}});
    directed_reqs.push_back('{'{OP_GET,    5'd2,  32'sd0},       1'b0, '{32'sd0, 5'd0, ST_OK}});
    directed_reqs.push_back('{'{OP_SET,    5'd1,  32'sh5555_5555}, 1'b0, '{32'sd0, 5'd0, ST_OK}});
    directed_reqs.push_back('{'{OP_GET,    5'd1,  32'sd0},       1'b0, '{32'sd0, 5'd0, ST_OK}});
    directed_reqs.push_back('{'{OP_DELETE, 5'd1,  32'sd0},       1'b0, '{32'sd0, 5'd0, ST_OK}});
    directed_reqs.push_back('{'{KIND_UNUSED, 5'd16, -32'sd1},    1'b0, '{32'sd0, 5'd0, ST_OK}});
    directed_reqs.push_back('{'{OP_POP,    5'd0,  32'sd0},       1'b0, '{32'sd0, 5'd0, ST_OK}});
    directed_reqs.push_back('{'{OP_DELETE, 5'd0,  32'sd0},       1'b0, '{32'sd0, 5'd0, ST_OK}});
    directed_reqs.push_back('{'{OP_GET,    5'd0,  32'sd0},       1'b0, '{32'sd0, 5'd0, ST_OK}});
    directed_reqs.push_back('{'{OP_POP,    5'd0,  32'sd0},       1'b0, '{32'sd0, 5'd0, ST_OK}});

    total = directed_reqs.size() + RAND_REQS;
    mix   = MIX_FILL;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (n = 0; n < total; n++) begin
      if (n < directed_reqs.size()) begin
        req = directed_reqs[n].req;
      end else begin
        // open with a fill phase so the full list shows up early
        if (n > directed_reqs.size() && (n - directed_reqs.size()) % PHASE_LEN == 0)
          mix = mix_t'($urandom_range(2));
        req = random_request(mix);
      end
      in_tvalid <= 1'b1;
      in_tuser  <= req.kind;
      in_tdata  <= {3'b000, req.value, req.position};
      do @(posedge clk); while (in_tready !== 1'b1);
      rsp = apply_list_op(req);
      if (n < directed_reqs.size() && directed_reqs[n].typed) rsp = directed_reqs[n].rsp;
      pending_rsps.push_back(rsp);

      idle = 0;
      pct  = (n >= 500 && n < 650) ? 0 : IDLE_PCT;
      while ($urandom_range(99) < pct) idle++;
      if (n == PAUSE_AT) idle++;
      if (idle > 0) begin
        in_tvalid <= 1'b0;
        if (n == PAUSE_AT) while (pending_rsps.size() != 0) @(posedge clk);
        repeat (idle) @(posedge clk);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : rsp_sink
    rsp_t        got;
    rsp_t        want;
    int unsigned cyc;
    int unsigned hold_left;
    cyc       = 0;
    hold_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready) begin
        got.read_value = out_tdata[31:0];
        got.length     = out_tdata[36:32];
        got.status     = status_t'(out_tdata[38:37]);
        if (pending_rsps.size() == 0) begin
          $error("unexpected response: tdata %h", out_tdata);
          mismatch_count++;
        end else begin
          want = pending_rsps.pop_front();
          if (got.read_value !== want.read_value) begin
            $error("read_value: expected %0d, actual %0d", want.read_value, got.read_value);
            mismatch_count++;
          end
          if (got.length !== want.length) begin
            $error("length: expected %0d, actual %0d", want.length, got.length);
            mismatch_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatch_count++;
          end
        end
      end
      cyc++;
      // back up the block while the source keeps offering
      if (cyc == 600) hold_left = 64;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (cyc > 1200 && cyc < 1700) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

endmodule

/* files.f */
rtl/iole_pkg.sv
rtl/iole_store.sv
rtl/indexed_ordered_list_engine_unit.sv
dv/indexed_ordered_list_engine_unit_tb.sv
